/* rtl/dfrs_pkg.sv */
// Shared types and constants for the deadline FIFO request scheduler.
`timescale 1ns / 1ps

package dfrs_pkg;

	// request kinds carried on the input channel
	typedef enum logic [1:0] {
		KIND_ADD      = 2'd0,
		KIND_DISPATCH = 2'd1,
		KIND_TICK     = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_SYNC_EXPIRE  = 2'd0,
		REG_ASYNC_EXPIRE = 2'd1,
		REG_BATCH_LIMIT  = 2'd2
	} reg_index_t;

	localparam int CFG_BITS   = 16;
	localparam int TAG_PORT_BITS = 8;

	localparam logic [CFG_BITS-1:0] SYNC_EXPIRE_RESET  = 16'd25;
	localparam logic [CFG_BITS-1:0] ASYNC_EXPIRE_RESET = 16'd200;
	localparam logic [CFG_BITS-1:0] BATCH_LIMIT_RESET  = 16'd1;
	localparam logic [CFG_BITS-1:0] BATCH_MAX          = 16'hFFFF;

	// queue occupancy flags
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

/* rtl/dfrs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dfrs_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/dfrs_queue.sv */
// One request FIFO: tag and deadline per entry, head entry always presented.
`timescale 1ns / 1ps

module dfrs_queue #(
	parameter int DEPTH    = 16,
	parameter int TAG_W    = 8,
	parameter int TIME_W   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [TAG_W-1:0]    push_tag,
	input  logic [TIME_W-1:0]   push_deadline,
	input  logic                pop,
	output logic [TAG_W-1:0]    head_tag,
	output logic [TIME_W-1:0]   head_deadline,
	output dfrs_pkg::q_status_t status
);

	import dfrs_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = TAG_W + TIME_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [IDX_W-1:0] head_q, tail_q, head_next, tail_next;
	logic [CNT_W-1:0] count_q;
	logic [ENT_W-1:0] wdata, rdata, head_data;
	logic             bypass_q;
	logic [ENT_W-1:0] bypass_data_q;

	// pointer advance with wrap at the last slot
	assign head_next = pop  ? ((head_q == LAST_IDX) ? '0 : head_q + 1'b1) : head_q;
	assign tail_next = push ? ((tail_q == LAST_IDX) ? '0 : tail_q + 1'b1) : tail_q;

	assign wdata = {push_tag, push_deadline};

	// entry storage; read address follows the next head pointer so the head is ready
	dfrs_ram #(
		.WIDTH(ENT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata(wdata),
		.raddr(head_next),
		.rdata(rdata)
	);

	// pointers, count and write-to-head forwarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			bypass_q <= 1'b0;
		end else begin
			head_q   <= head_next;
			tail_q   <= tail_next;
			bypass_q <= push && (tail_q == head_next);
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		bypass_data_q <= wdata;
	end

	assign head_data     = bypass_q ? bypass_data_q : rdata;
	assign head_tag      = head_data[ENT_W-1:TIME_W];
	assign head_deadline = head_data[TIME_W-1:0];
	assign status.empty  = (count_q == '0);
	assign status.full   = (count_q == FULL_CNT);

	// checks
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full || pop)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("pop from empty queue");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(status.empty || status.full) |-> head_q == tail_q)
		else $error("pointers disagree with count");

endmodule

/* rtl/deadline_fifo_request_scheduler.sv */
// Top level of the two-class deadline FIFO request scheduler.
`timescale 1ns / 1ps

// Takes one request per clock while in_ready is high and answers each with
// exactly one result in the following cycle from a result register; in_ready
// is high whenever that register is empty or being taken, so with out_ready
// held high a request enters every cycle. All decisions for a request (queue
// heads, the three wrap-safe deadline compares, batch and tick counters) are
// made in the cycle it is accepted. Each queue keeps its entries in a RAM
// whose read address is the next head pointer, so the head entry is always
// ready; a write to the slot becoming head is forwarded. No clearing pass
// after reset. Configuration writes are registered and are meant for idle
// periods only.

module deadline_fifo_request_scheduler #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TAG_BITS    = 8,
	parameter int TIME_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// request channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  request_tag,
	input  logic        is_sync,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        accepted,
	output logic [7:0]  out_tag,
	output logic        out_sync,
	output logic        by_deadline
);

	import dfrs_pkg::*;

	// stored tags never hold more bits than the tag port carries
	localparam int STORE_TAG_BITS = (TAG_BITS < TAG_PORT_BITS) ? TAG_BITS : TAG_PORT_BITS;

	logic [CFG_BITS-1:0]  sync_exp_q, async_exp_q, batch_limit_q, batch_q, batch_next;
	logic [TIME_BITS-1:0] now_q;
	logic                 out_valid_q;
	logic                 accepted_q, out_sync_q, by_deadline_q;
	logic [7:0]           out_tag_q;

	logic fire, is_add, is_disp, is_tick;
	logic [CFG_BITS-1:0]  add_exp;
	logic [TIME_BITS-1:0] add_deadline;
	logic [STORE_TAG_BITS-1:0] add_tag, s_tag, a_tag;
	logic [TIME_BITS-1:0] s_dl, a_dl, s_diff, a_diff, sa_diff;
	q_status_t s_st, a_st;
	logic add_ok, push_s, push_a, pop_s, pop_a;
	logic check, se, ae, dl_sync, dl_async, pick_sync, pick_async;
	logic res_accepted;
	logic [7:0] res_tag;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign is_add   = fire && (kind == KIND_ADD);
	assign is_disp  = fire && (kind == KIND_DISPATCH);
	assign is_tick  = fire && (kind == KIND_TICK);

	// add path
	assign add_exp      = is_sync ? sync_exp_q : async_exp_q;
	assign add_deadline = now_q + TIME_BITS'(add_exp);
	assign add_tag      = STORE_TAG_BITS'(request_tag);
	assign add_ok       = (add_exp != '0) && !(is_sync ? s_st.full : a_st.full);
	assign push_s       = is_add && is_sync && add_ok;
	assign push_a       = is_add && !is_sync && add_ok;

	// deadline checks on the heads, wrap-safe
	assign check    = (batch_q > batch_limit_q);
	assign s_diff   = s_dl - now_q;
	assign a_diff   = a_dl - now_q;
	assign sa_diff  = s_dl - a_dl;
	assign se       = !s_st.empty && s_diff[TIME_BITS-1];
	assign ae       = !a_st.empty && a_diff[TIME_BITS-1];
	assign dl_sync  = check && se && (!ae || sa_diff[TIME_BITS-1]);
	assign dl_async = check && ae && !se;

	// pick: deadline winner first, else sync before async
	assign pick_sync  = dl_sync || (!dl_async && !s_st.empty);
	assign pick_async = dl_async || (!dl_sync && s_st.empty && !a_st.empty);
	assign pop_s      = is_disp && pick_sync;
	assign pop_a      = is_disp && pick_async;

	// batch counter: cleared when the check is due, saturating increment
	always_comb begin
		batch_next = batch_q;
		if (is_disp) begin
			if (check) begin
				batch_next = '0;
			end
			if ((pick_sync || pick_async) && (batch_next != BATCH_MAX)) begin
				batch_next = batch_next + 1'b1;
			end
		end
	end

	// result fields
	always_comb begin
		res_accepted = 1'b0;
		res_tag      = '0;
		case (kind)
			KIND_ADD:      res_accepted = add_ok;
			KIND_DISPATCH: begin
				res_accepted = pick_sync || pick_async;
				if (pick_sync) begin
					res_tag = 8'(s_tag);
				end else if (pick_async) begin
					res_tag = 8'(a_tag);
				end
			end
			KIND_TICK:     res_accepted = 1'b1;
			default:       res_accepted = 1'b0;
		endcase
	end

	dfrs_queue #(
		.DEPTH (QUEUE_DEPTH),
		.TAG_W (STORE_TAG_BITS),
		.TIME_W(TIME_BITS)
	) u_sync_q (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push_s),
		.push_tag     (add_tag),
		.push_deadline(add_deadline),
		.pop          (pop_s),
		.head_tag     (s_tag),
		.head_deadline(s_dl),
		.status       (s_st)
	);

	dfrs_queue #(
		.DEPTH (QUEUE_DEPTH),
		.TAG_W (STORE_TAG_BITS),
		.TIME_W(TIME_BITS)
	) u_async_q (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push_a),
		.push_tag     (add_tag),
		.push_deadline(add_deadline),
		.pop          (pop_a),
		.head_tag     (a_tag),
		.head_deadline(a_dl),
		.status       (a_st)
	);

	// configuration registers, tick time and batch counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_exp_q    <= SYNC_EXPIRE_RESET;
			async_exp_q   <= ASYNC_EXPIRE_RESET;
			batch_limit_q <= BATCH_LIMIT_RESET;
			now_q         <= '0;
			batch_q       <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_SYNC_EXPIRE:  sync_exp_q    <= cfg_data;
					REG_ASYNC_EXPIRE: async_exp_q   <= cfg_data;
					REG_BATCH_LIMIT:  batch_limit_q <= cfg_data;
					default:          ;
				endcase
			end
			if (is_tick) begin
				now_q <= now_q + 1'b1;
			end
			batch_q <= batch_next;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_q    <= res_accepted;
			out_tag_q     <= res_tag;
			out_sync_q    <= is_disp && pick_sync;
			by_deadline_q <= is_disp && (dl_sync || dl_async);
		end
	end

	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign out_tag     = out_tag_q;
	assign out_sync    = out_sync_q;
	assign by_deadline = by_deadline_q;

	// checks
	a_dl_implies_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (by_deadline || out_sync)) |-> accepted)
		else $error("deadline or sync flag without a dispatched request");
	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(is_disp && check) |=> (batch_q <= 16'd1))
		else $error("batch counter not cleared on check");
	a_zero_expire: assert property (@(posedge clk) disable iff (!arst_n)
		(is_add && is_sync && (sync_exp_q == '0)) |=> (out_valid && !accepted))
		else $error("add taken with zero expire time");
	a_single_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop_s && pop_a) && !((push_s || push_a) && (pop_s || pop_a)))
		else $error("more than one queue operation per request");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the deadline FIFO request scheduler.
`timescale 1ns / 1ps

module tb_top;
	import dfrs_pkg::*;

	localparam int DEPTH = 16;
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 105;
	localparam int MODE_FILL = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIXED = 2;

	typedef struct packed {
		logic       accepted;
		logic [7:0] tag;
		logic       sync;
		logic       by_deadline;
	} sched_result_t;

	// Mirror of both queues, tick clock and batch counter; keeps expected results.
	// Queue index 1 is the sync class, 0 the async class.
	class sched_scoreboard;
		logic [7:0]    q_tag [2][DEPTH];
		logic [31:0]   q_due [2][DEPTH];
		int            q_head [2];
		int            q_count [2];
		logic [31:0]   now_ticks;
		logic [15:0]   batch_count;
		logic [15:0]   expire_ticks [2];
		logic [15:0]   batch_limit;
		sched_result_t expected_results [$];
		int            mismatches;
		int            requests;
		int            results;
		int            refused;
		int            deadline_picks;

		function new();
			now_ticks = '0;
			batch_count = '0;
			expire_ticks[1] = SYNC_EXPIRE_RESET;
			expire_ticks[0] = ASYNC_EXPIRE_RESET;
			batch_limit = BATCH_LIMIT_RESET;
			q_head = '{0, 0};
			q_count = '{0, 0};
			mismatches = 0;
			requests = 0;
			results = 0;
			refused = 0;
			deadline_picks = 0;
		endfunction

		function void write_reg(reg_index_t idx, logic [15:0] value);
			case (idx)
			REG_SYNC_EXPIRE: expire_ticks[1] = value;
			REG_ASYNC_EXPIRE: expire_ticks[0] = value;
			REG_BATCH_LIMIT: batch_limit = value;
			default: ;
			endcase
		endfunction

		// wrap-safe: time a lies after time b
		function bit later(logic [31:0] a, logic [31:0] b);
			logic [31:0] diff;
			diff = b - a;
			return diff[31];
		endfunction

		function bit head_overdue(int c);
			return q_count[c] != 0 && later(now_ticks, q_due[c][q_head[c]]);
		endfunction

		// apply one accepted request to the mirror and queue its result
		function void note_request(logic [1:0] k, logic [7:0] tag, logic cls);
			sched_result_t r;
			int pick;
			int slot;
			bit overdue_pick;
			bit s_late;
			bit a_late;
			r = '0;
			pick = -1;
			overdue_pick = 1'b0;
			requests++;
			if (k == KIND_ADD) begin
				if (expire_ticks[cls] != 0 && q_count[cls] < DEPTH) begin
					slot = (q_head[cls] + q_count[cls]) % DEPTH;
					q_tag[cls][slot] = tag;
					q_due[cls][slot] = now_ticks + 32'(expire_ticks[cls]);
					q_count[cls]++;
					r.accepted = 1'b1;
				end else begin
					refused++;
				end
			end else if (k == KIND_DISPATCH) begin
				// deadline check once the batch has run past its limit
				if (batch_count > batch_limit) begin
					s_late = head_overdue(1);
					a_late = head_overdue(0);
					batch_count = '0;
					if (s_late && a_late) begin
						if (later(q_due[0][q_head[0]], q_due[1][q_head[1]])) begin
							pick = 1;
							overdue_pick = 1'b1;
						end
					end else if (s_late) begin
						pick = 1;
						overdue_pick = 1'b1;
					end else if (a_late) begin
						pick = 0;
						overdue_pick = 1'b1;
					end
				end
				// normal order: sync before async
				if (pick < 0) begin
					if (q_count[1] != 0)
						pick = 1;
					else if (q_count[0] != 0)
						pick = 0;
				end
				if (pick >= 0) begin
					r.accepted = 1'b1;
					r.tag = q_tag[pick][q_head[pick]];
					r.sync = (pick == 1);
					r.by_deadline = overdue_pick;
					q_head[pick] = (q_head[pick] + 1) % DEPTH;
					q_count[pick]--;
					if (batch_count != BATCH_MAX)
						batch_count++;
					if (overdue_pick)
						deadline_picks++;
				end
			end else if (k == KIND_TICK) begin
				now_ticks++;
				r.accepted = 1'b1;
			end
			expected_results.push_back(r);
		endfunction

		function void compare_field(string field, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				mismatches++;
				$display("%0t ERROR: %s expected %0h, actual %0h", $time, field, want, got);
			end
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t want;
			results++;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t ERROR: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = expected_results.pop_front();
			compare_field("accepted", 8'(want.accepted), 8'(got.accepted));
			compare_field("out_tag", want.tag, got.tag);
			compare_field("out_sync", 8'(want.sync), 8'(got.sync));
			compare_field("by_deadline", 8'(want.by_deadline), 8'(got.by_deadline));
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = REG_SYNC_EXPIRE;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = KIND_ADD;
	logic [7:0]  request_tag = '0;
	logic        is_sync = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        accepted;
	logic [7:0]  out_tag;
	logic        out_sync;
	logic        by_deadline;

	bit              idling = 1'b1;
	int              stall_left = 0;
	int              cycles = 0;
	sched_scoreboard sb = new();

	deadline_fifo_request_scheduler dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.request_tag(request_tag),
		.is_sync    (is_sync),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.out_tag    (out_tag),
		.out_sync   (out_sync),
		.by_deadline(by_deadline)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// cycle counter and run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
		$display("tb_top: FAIL");
		$finish;
	end

	// result side: random stall bursts on out_ready, started only while idling is set
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idling && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(sched_result_t'{accepted, out_tag, out_sync, by_deadline});
	end

	// one request through the handshake, with an optional gap in front
	task automatic send(logic [1:0] k, logic [7:0] tag, logic cls);
		int gap;
		if (idling && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		request_tag <= tag;
		is_sync <= cls;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_request(k, tag, cls);
	endtask

	// hold off the sender until every expected result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [15:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.write_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic set_config(logic [15:0] sync_exp, logic [15:0] async_exp,
			logic [15:0] limit);
		write_reg(REG_SYNC_EXPIRE, sync_exp);
		write_reg(REG_ASYNC_EXPIRE, async_exp);
		write_reg(REG_BATCH_LIMIT, limit);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [1:0] pick_kind(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return KIND_UNUSED;
		case (mode)
		MODE_FILL: return r < 75 ? KIND_ADD : (r < 85 ? KIND_DISPATCH : KIND_TICK);
		MODE_DRAIN: return r < 20 ? KIND_ADD : (r < 75 ? KIND_DISPATCH : KIND_TICK);
		default: return r < 45 ? KIND_ADD : (r < 75 ? KIND_DISPATCH : KIND_TICK);
		endcase
	endfunction

	// stimulus
	initial begin
		int mode;
		logic bias_sync;
		logic cls;
		logic [1:0] k;
		mode = MODE_MIXED;
		bias_sync = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: empty dispatch, unused kind, plain FIFO order
		send(KIND_DISPATCH, 8'h3C, 1'b0);
		send(KIND_UNUSED, 8'hFF, 1'b1);
		send(KIND_ADD, 8'h00, 1'b1);
		send(KIND_ADD, 8'hFF, 1'b0);
		send(KIND_TICK, 8'hA5, 1'b1);
		send(KIND_DISPATCH, 8'h00, 1'b1);
		send(KIND_DISPATCH, 8'hFF, 1'b0);
		drain();

		// short expire times: sync overdue, async overdue, both overdue
		set_config(16'd1, 16'd3, 16'd0);
		send(KIND_ADD, 8'h00, 1'b1);
		send(KIND_ADD, 8'hFF, 1'b0);
		send(KIND_ADD, 8'h5A, 1'b1);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_TICK, 8'hFF, 1'b1);
		send(KIND_DISPATCH, 8'h12, 1'b0);
		send(KIND_DISPATCH, 8'h34, 1'b1);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_ADD, 8'hA5, 1'b1);
		send(KIND_DISPATCH, 8'h00, 1'b0);
		send(KIND_ADD, 8'h0F, 1'b0);
		repeat (4) send(KIND_TICK, 8'h00, 1'b0);
		send(KIND_DISPATCH, 8'h00, 1'b0);
		send(KIND_DISPATCH, 8'h00, 1'b1);

		// random phases, each under its own settings
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
			0: set_config(SYNC_EXPIRE_RESET, ASYNC_EXPIRE_RESET, BATCH_LIMIT_RESET);
			1: set_config(16'd0, 16'hFFFF, 16'd0);
			2: set_config(16'hFFFF, 16'd0, 16'hFFFF);
			3: set_config(16'd1, 16'd1, 16'd0);
			default: set_config(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
					16'($urandom_range(0, 3)));
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 20 == 0) begin
					mode = $urandom_range(MODE_FILL, MODE_MIXED);
					bias_sync = 1'($urandom_range(0, 1));
					idling = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
				end
				if (p == 3 && n == 50)
					drain();
				k = pick_kind(mode);
				// fill bursts lean on one class so its queue runs full
				if (mode == MODE_FILL)
					cls = ($urandom_range(0, 4) != 0) ? bias_sync : ~bias_sync;
				else
					cls = 1'($urandom_range(0, 1));
				send(k, 8'($urandom_range(0, 255)), cls);
			end
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d requests and %0d results: %0d adds refused, %0d deadline picks",
			sb.requests, sb.results, sb.refused, sb.deadline_picks);
		$display("Settings ran from reset values through zero and full-scale expire and limits");
		if (sb.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
